@@ hdl/tnohe_pkg.sv @@
// ---------------------------------------------------------------------------
// tnohe_pkg
// Shared types and constants of the toroidal neighborhood one-hot encoder.
// ---------------------------------------------------------------------------
package tnohe_pkg;

  // Operation codes of an input word
  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_ENCODE = 1'b1;

  // Configuration register indexes
  localparam logic [1:0] CFG_GRID_SIZE  = 2'd0;
  localparam logic [1:0] CFG_RADIUS     = 2'd1;
  localparam logic [1:0] CFG_NUM_STATES = 2'd2;

  // Grid side, reach and state count limits; the field widths below follow them
  localparam int GRID_MAX   = 64;
  localparam int MAX_RADIUS = 3;
  localparam int MAX_STATES = 16;

  // Field and register widths
  localparam int CFG_W    = 7;
  localparam int IDX_W    = 2;
  localparam int GSIZE_W  = 7;
  localparam int RAD_W    = 2;
  localparam int NST_W    = 5;
  localparam int COORD_W  = 6;
  localparam int VAL_W    = 4;
  localparam int HOT_W    = 16;
  localparam int NUM_W    = 6;
  localparam int STEP_W   = 3;
  // Signed width for coordinate wrap arithmetic and grid size compares
  localparam int CRD_W    = 10;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;            // latch the input word
    logic write_cell;      // store the latched value into the grid
    logic read_centre;     // read the addressed cell
    logic capture_centre;  // hold the centre state from the read data
    logic walk_start;      // reset the walk counters and coordinates
    logic walk_issue;      // read the current neighbor and tag it
    logic walk_advance;    // step to the next neighborhood position
  } ctrl_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic op;              // latched operation
    logic in_range;        // latched cell lies inside the grid in use
    logic rad_zero;        // effective radius is zero
    logic step_centre;     // walk sits on the centre position
    logic step_last;       // walk sits on the final position
    logic credit_ok;       // output queue can take one more read
  } dp_status_t;

  // One result word
  typedef struct packed {
    logic [HOT_W-1:0] one_hot;
    logic [VAL_W-1:0] state;
    logic [NUM_W-1:0] number;
    logic [VAL_W-1:0] center;
    logic             last;
  } out_item_t;

endpackage

@@ hdl/toroidal_neighborhood_one_hot_encoder.sv @@
// ---------------------------------------------------------------------------
// toroidal_neighborhood_one_hot_encoder
// Square toroidal cell grid with Moore-neighborhood one-hot result stream.
// ---------------------------------------------------------------------------
// A write word is accepted, then written into the grid. An encode word is
// accepted and decoded, the centre cell is read, then the walk visits each
// neighborhood position in turn (the centre position is passed without a
// result). The single read port of the cell grid memory allows one neighbor
// read per cycle while the output queue has room.
// Results leave through a two-entry queue, so a stall on the output only
// pauses the walk. Cells must be written before they are read.
module toroidal_neighborhood_one_hot_encoder (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wr_en,
  input  logic [tnohe_pkg::IDX_W-1:0]   cfg_index,
  input  logic [tnohe_pkg::CFG_W-1:0]   cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          op,
  input  logic [tnohe_pkg::COORD_W-1:0] row,
  input  logic [tnohe_pkg::COORD_W-1:0] col,
  input  logic [tnohe_pkg::VAL_W-1:0]   cell_value,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [tnohe_pkg::HOT_W-1:0]   neighbor_one_hot,
  output logic [tnohe_pkg::VAL_W-1:0]   neighbor_state,
  output logic [tnohe_pkg::NUM_W-1:0]   neighbor_number,
  output logic [tnohe_pkg::VAL_W-1:0]   center_state,
  output logic                          last
);
  import tnohe_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t sts;
  out_item_t  out_item;

  tnohe_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  tnohe_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .op         (op),
    .row        (row),
    .col        (col),
    .cell_value (cell_value),
    .cmd        (cmd),
    .sts        (sts),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_item   (out_item)
  );

  // Unpack the result word
  assign neighbor_one_hot = out_item.one_hot;
  assign neighbor_state   = out_item.state;
  assign neighbor_number  = out_item.number;
  assign center_state     = out_item.center;
  assign last             = out_item.last;

endmodule

@@ hdl/tnohe_ctrl.sv @@
// ---------------------------------------------------------------------------
// tnohe_ctrl
// Controller: sequences accept, decode, centre read and the neighborhood walk.
// ---------------------------------------------------------------------------
module tnohe_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  tnohe_pkg::dp_status_t sts,
  output tnohe_pkg::ctrl_cmd_t  cmd
);
  import tnohe_pkg::*;

  typedef enum logic [1:0] {
    IDLE,
    DECODE,
    CENTRE,
    WALK
  } state_t;

  state_t state;
  state_t state_next;

  // Decode commands and next state
  always_comb begin
    cmd        = '0;
    state_next = state;
    in_ready   = 1'b0;
    case (state)
      IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = DECODE;
        end
      end
      DECODE: begin
        if (!sts.in_range) begin
          state_next = IDLE;
        end else if (sts.op == OP_WRITE) begin
          cmd.write_cell = 1'b1;
          state_next     = IDLE;
        end else if (sts.rad_zero) begin
          state_next = IDLE;
        end else begin
          cmd.read_centre = 1'b1;
          cmd.walk_start  = 1'b1;
          state_next      = CENTRE;
        end
      end
      CENTRE: begin
        cmd.capture_centre = 1'b1;
        state_next         = WALK;
      end
      WALK: begin
        // skip the centre, otherwise issue one read when the queue has room
        if (sts.step_centre) begin
          cmd.walk_advance = 1'b1;
        end else if (sts.credit_ok) begin
          cmd.walk_issue   = 1'b1;
          cmd.walk_advance = 1'b1;
          if (sts.step_last) begin
            state_next = IDLE;
          end
        end
      end
      default: begin
        state_next = IDLE;
      end
    endcase
  end

  // Hold state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      state <= state_next;
    end
  end

  a_issue_has_credit: assert property (@(posedge clk) disable iff (rst)
    cmd.walk_issue |-> sts.credit_ok)
    else $error("neighbor read issued without queue room");

  a_no_centre_result: assert property (@(posedge clk) disable iff (rst)
    cmd.walk_issue |-> !sts.step_centre)
    else $error("centre cell issued as a neighbor");

  a_accept_decodes: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == DECODE))
    else $error("accepted word not decoded");

endmodule

@@ hdl/tnohe_dp.sv @@
// ---------------------------------------------------------------------------
// tnohe_dp
// Datapath: configuration, cell grid memory, toroidal walk and output queue.
// ---------------------------------------------------------------------------
module tnohe_dp (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_wr_en,
  input  logic [tnohe_pkg::IDX_W-1:0]       cfg_index,
  input  logic [tnohe_pkg::CFG_W-1:0]       cfg_data,
  input  logic                              op,
  input  logic [tnohe_pkg::COORD_W-1:0]     row,
  input  logic [tnohe_pkg::COORD_W-1:0]     col,
  input  logic [tnohe_pkg::VAL_W-1:0]       cell_value,
  input  tnohe_pkg::ctrl_cmd_t              cmd,
  output tnohe_pkg::dp_status_t             sts,
  output logic                              out_valid,
  input  logic                              out_ready,
  output tnohe_pkg::out_item_t              out_item
);
  import tnohe_pkg::*;

  localparam int CW    = (GRID_MAX > 1) ? $clog2(GRID_MAX) : 1;
  localparam int DEPTH = GRID_MAX * GRID_MAX;
  localparam int AW    = $clog2(DEPTH);

  // Configuration registers
  logic [GSIZE_W-1:0] grid_size;
  logic [RAD_W-1:0]   radius;
  logic [NST_W-1:0]   num_states;

  // Latched input word
  logic               op_r;
  logic [COORD_W-1:0] row_r;
  logic [COORD_W-1:0] col_r;
  logic [VAL_W-1:0]   val_r;

  // Effective configuration
  logic [CRD_W-1:0]   size_eff;
  logic [RAD_W-1:0]   rad_eff;
  logic [STEP_W-1:0]  side_m1;
  logic [STEP_W-1:0]  rad_step;
  logic [6:0]         ns_eff;

  // Walk state
  logic [STEP_W-1:0]  row_step;
  logic [STEP_W-1:0]  col_step;
  logic [CW-1:0]      cur_r;
  logic [CW-1:0]      cur_c;
  logic [CW-1:0]      start_c;
  logic [NUM_W-1:0]   number;

  // Memory and read tag
  logic [VAL_W-1:0]   cell_grid [DEPTH];
  logic [AW-1:0]      centre_addr;
  logic [AW-1:0]      rd_addr;
  logic [VAL_W-1:0]   rd_data;
  logic               inflight;
  logic [NUM_W-1:0]   tag_number;
  logic               tag_last;
  logic [VAL_W-1:0]   center;

  // Output queue
  out_item_t          slot [2];
  logic [1:0]         cnt;
  logic               push;
  logic               pop;
  logic [2:0]         occ_next;
  out_item_t          new_item;
  logic [HOT_W-1:0]   hot;

  function automatic logic [AW-1:0] cell_addr(input logic [CW-1:0] r,
                                              input logic [CW-1:0] c);
    cell_addr = AW'(r) * AW'(GRID_MAX) + AW'(c);
  endfunction

  // Wrap base minus radius back into the grid
  function automatic logic [CW-1:0] wrap_start(input logic [COORD_W-1:0] base,
                                               input logic [RAD_W-1:0]   rad,
                                               input logic [CRD_W-1:0]   size);
    logic signed [CRD_W-1:0] v;
    v = $signed(CRD_W'(base)) - $signed(CRD_W'(rad));
    if (v < 0) v = v + $signed(size);
    if (v < 0) v = v + $signed(size);
    wrap_start = CW'(v);
  endfunction

  // Step one cell forward with wrap at the grid edge
  function automatic logic [CW-1:0] wrap_inc(input logic [CW-1:0]    x,
                                             input logic [CRD_W-1:0] size);
    logic [CRD_W-1:0] n;
    n = CRD_W'(x) + CRD_W'(1);
    wrap_inc = (n == size) ? '0 : CW'(n);
  endfunction

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_size  <= GSIZE_W'(64);
      radius     <= RAD_W'(1);
      num_states <= NST_W'(2);
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_GRID_SIZE:  grid_size  <= cfg_data[GSIZE_W-1:0];
        CFG_RADIUS:     radius     <= cfg_data[RAD_W-1:0];
        CFG_NUM_STATES: num_states <= cfg_data[NST_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Clamp configuration into the supported range
  always_comb begin
    logic [CRD_W-1:0] gs;
    gs = CRD_W'(grid_size);
    if (gs > CRD_W'(GRID_MAX)) gs = CRD_W'(GRID_MAX);
    if (gs < CRD_W'(2)) gs = CRD_W'(2);
    size_eff = gs;
    rad_eff  = (STEP_W'(radius) > STEP_W'(MAX_RADIUS)) ? RAD_W'(MAX_RADIUS) : radius;
    ns_eff   = (7'(num_states) > 7'(MAX_STATES)) ? 7'(MAX_STATES) : 7'(num_states);
  end

  assign rad_step = STEP_W'(rad_eff);
  assign side_m1  = {rad_eff, 1'b0};

  // Latch the input word
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= op;
      row_r <= row;
      col_r <= col;
      val_r <= cell_value;
    end
  end

  // Walk the neighborhood row-offset major
  always_ff @(posedge clk) begin
    if (cmd.walk_start) begin
      row_step <= '0;
      col_step <= '0;
      cur_r    <= wrap_start(row_r, rad_eff, size_eff);
      cur_c    <= wrap_start(col_r, rad_eff, size_eff);
      start_c  <= wrap_start(col_r, rad_eff, size_eff);
      number   <= '0;
    end else begin
      if (cmd.walk_advance) begin
        if (col_step == side_m1) begin
          col_step <= '0;
          cur_c    <= start_c;
          row_step <= row_step + STEP_W'(1);
          cur_r    <= wrap_inc(cur_r, size_eff);
        end else begin
          col_step <= col_step + STEP_W'(1);
          cur_c    <= wrap_inc(cur_c, size_eff);
        end
      end
      if (cmd.walk_issue) begin
        number <= number + NUM_W'(1);
      end
    end
  end

  // Cell grid: one write and one read address per cycle, registered read
  assign centre_addr = cell_addr(CW'(row_r), CW'(col_r));
  assign rd_addr     = cmd.read_centre ? centre_addr : cell_addr(cur_r, cur_c);

  always_ff @(posedge clk) begin
    if (cmd.write_cell) begin
      cell_grid[centre_addr] <= val_r;
    end
    rd_data <= cell_grid[rd_addr];
  end

  // Track the read in flight and its tag
  always_ff @(posedge clk) begin
    if (rst) begin
      inflight <= 1'b0;
    end else begin
      inflight <= cmd.walk_issue;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.walk_issue) begin
      tag_number <= number;
      tag_last   <= (row_step == side_m1) && (col_step == side_m1);
    end
    if (cmd.capture_centre) begin
      center <= rd_data;
    end
  end

  // Build the result word from the read data
  always_comb begin
    for (int i = 0; i < HOT_W; i++) begin
      hot[i] = (rd_data == VAL_W'(i)) && (7'(i) < ns_eff);
    end
    new_item.one_hot = hot;
    new_item.state   = rd_data;
    new_item.number  = tag_number;
    new_item.center  = center;
    new_item.last    = tag_last;
  end

  // Two-entry output queue, head in slot zero
  assign push      = inflight;
  assign pop       = out_valid && out_ready;
  assign out_valid = (cnt != 2'd0);
  assign out_item  = slot[0];
  assign occ_next  = 3'(cnt) + 3'(inflight) - 3'(pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else begin
      cnt <= 2'(3'(cnt) + 3'(push) - 3'(pop));
    end
  end

  // Load the head from the new word or shift the tail forward
  always_ff @(posedge clk) begin
    if (push && (cnt == 2'd0 || (cnt == 2'd1 && pop))) begin
      slot[0] <= new_item;
    end else if (pop) begin
      slot[0] <= slot[1];
    end
    if (push && (cnt == 2'd2 || (cnt == 2'd1 && !pop))) begin
      slot[1] <= new_item;
    end
  end

  // Status toward the controller
  assign sts.op          = op_r;
  assign sts.in_range    = (CRD_W'(row_r) < size_eff) && (CRD_W'(col_r) < size_eff);
  assign sts.rad_zero    = (rad_eff == '0);
  assign sts.step_centre = (row_step == rad_step) && (col_step == rad_step);
  assign sts.step_last   = (row_step == side_m1) && (col_step == side_m1);
  assign sts.credit_ok   = (occ_next < 3'd2);

  a_queue_no_overflow: assert property (@(posedge clk) disable iff (rst)
    (inflight && cnt == 2'd2) |-> pop)
    else $error("output queue overflow");

  a_centre_clean: assert property (@(posedge clk) disable iff (rst)
    cmd.capture_centre |-> !inflight)
    else $error("centre capture collides with a neighbor read");

endmodule
